@@ rtl/mtm_pkg.sv @@
// shared types, constants and helper functions for the midi thru / merge block
// no dependencies; imported by mtm_queue and midi_thru_merge_sysex_guard
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

    localparam int APP_QUEUE_DEPTH = 16;
    localparam int QIDX_W          = (APP_QUEUE_DEPTH > 1) ? $clog2(APP_QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(APP_QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS     = 16;
    localparam int RCNT_W          = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_EOX   = 8'hF7;
    localparam logic [7:0] RT_MASK  = 8'hF8;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    localparam logic [0:0] REG_ENABLE  = 1'd0;
    localparam logic [0:0] REG_TIMEOUT = 1'd1;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_MESSAGE = 2'd1,
        FUNC_ENQUEUE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        DEST_MIDI   = 2'd0,
        DEST_APP    = 2'd1,
        DEST_STATUS = 2'd2
    } dest_t;

    typedef enum logic [2:0] {
        CODE_OK       = 3'd0,
        CODE_REFUSED  = 3'd1,
        CODE_STRAY    = 3'd2,
        CODE_FULL     = 3'd3,
        CODE_INACTIVE = 3'd4
    } code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_STATUS,
        S_THRU_OUT,
        S_THRU_APP,
        S_FETCH,
        S_DUE,
        S_TDIFF,
        S_TCMP,
        S_POP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic has_eox(input logic [31:0] m);
        has_eox = (m[7:0] == ST_EOX) || (m[15:8] == ST_EOX) ||
                  (m[23:16] == ST_EOX) || (m[31:24] == ST_EOX);
    endfunction

    function automatic logic is_realtime(input logic [7:0] st);
        is_realtime = ((st & RT_MASK) == RT_MASK);
    endfunction

    function automatic logic track_sysex(input logic busy, input logic [31:0] m);
        logic b;
        b = busy;
        if (m[7:0] == ST_SYSEX)
        begin
            b = 1'b1;
        end
        else if (!is_realtime(m[7:0]))
        begin
            b = 1'b0;
        end
        if (b && has_eox(m))
        begin
            b = 1'b0;
        end
        track_sysex = b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mtm_queue.sv @@
// application message queue: circular buffer of message / due tick pairs
// uses mtm_pkg; head entry is read through a registered port
`timescale 1ns / 1ps
`default_nettype none

module mtm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [31:0]       push_msg,
    input  wire logic [31:0]       push_due,
    input  wire logic              pop,
    output logic [31:0]            head_msg,
    output logic [31:0]            head_due,
    output mtm_pkg::q_status_t     stat
);
    import mtm_pkg::*;

    logic [31:0]       msg_mem [APP_QUEUE_DEPTH];
    logic [31:0]       due_mem [APP_QUEUE_DEPTH];
    logic [QIDX_W-1:0] head_reg;
    logic [QIDX_W-1:0] head_next;
    logic [QIDX_W-1:0] tail_reg;
    logic [QIDX_W-1:0] tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [31:0]       rd_msg_reg;
    logic [31:0]       rd_due_reg;

    localparam logic [QIDX_W-1:0] LAST_IDX = QIDX_W'(APP_QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(APP_QUEUE_DEPTH);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            msg_mem[tail_reg] <= push_msg;
            due_mem[tail_reg] <= push_due;
        end
        rd_msg_reg <= msg_mem[head_reg];
        rd_due_reg <= due_mem[head_reg];
    end

    assign head_msg   = rd_msg_reg;
    assign head_due   = rd_due_reg;
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/midi_thru_merge_sysex_guard.sv @@
// top level of the midi thru / merge block with sysex blocking
// uses mtm_pkg and mtm_queue
//
// usage: the slave stream carries one request per transaction (tuser = func: tick,
// midi input message or application enqueue); the master stream returns the
// results of that request, tlast on the final one. the config channel writes
// enable (index 0) and sysex_timeout (index 1); cfg_ready is always high.
// a midi input message gives two results (output port, application) or one
// status result; an enqueue or a refused / dropped request gives one status.
// a tick bumps the time and drains due queue heads one at a time through a
// single shared 32-bit subtractor that does the tick increment, the due test
// and the timeout test in turn.
// s_axis_tready is high only while the sequencer is idle; a result waits in
// the output register while the receiver stalls and the sequencer holds.
// reset clears time, sysex flags, queue pointers and config to their defaults;
// queue contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module midi_thru_merge_sysex_guard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // message[31:0], due_time[63:32]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // message_res[31:0], stamp[63:32]
    output logic [4:0]       m_axis_tuser,   // dest[1:0], code[4:2]
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mtm_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic        enable_reg;
    logic [15:0] timeout_reg;
    logic [31:0] tick_reg;
    logic [31:0] last_in_reg;
    logic        thru_busy_reg;
    logic        app_busy_reg;
    logic [1:0]  func_reg;
    logic [31:0] msg_reg;
    logic [31:0] due_reg;
    code_t       code_reg;
    logic [31:0] pend_msg_reg;
    logic        pend_valid_reg;
    logic [31:0] diff_reg;
    logic [RCNT_W-1:0] n_reg;

    logic        out_valid_reg;
    logic [31:0] out_msg_reg;
    logic [31:0] out_stamp_reg;
    dest_t       out_dest_reg;
    code_t       out_code_reg;
    logic        out_last_reg;

    logic        in_take;
    logic        out_free;

    // shared subtractor
    logic [31:0] unit_a;
    logic [31:0] unit_b;
    logic [32:0] unit_res;
    logic        unit_borrow;

    // queue
    logic        q_push;
    logic        q_pop;
    logic [31:0] q_msg;
    logic [31:0] q_due;
    q_status_t   q_stat;

    // control
    logic        out_load;
    dest_t       out_dest;
    logic [31:0] out_msg;
    code_t       out_code;
    logic        out_last;
    logic        tick_load;
    logic        last_in_load;
    logic        code_load;
    code_t       code_val;
    logic        thru_clear;
    logic        thru_update;
    logic        app_update;
    logic        pend_load;
    logic        pend_clear;
    logic        diff_load;
    logic        n_clear;

    logic        head_blocked;
    logic        n_max;

    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign n_max         = (n_reg == RCNT_W'(MAX_RESULTS));
    assign head_blocked  = !is_realtime(q_msg[7:0]) && thru_busy_reg;

    mtm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_msg (msg_reg),
        .push_due (due_reg),
        .pop      (q_pop),
        .head_msg (q_msg),
        .head_due (q_due),
        .stat     (q_stat)
    );

    // operand select for the shared subtractor
    always_comb
    begin
        unit_a = tick_reg;
        unit_b = '1;                 // tick - (-1) gives tick + 1
        case (state_reg)
            S_DUE:
            begin
                unit_b = q_due;
            end
            S_TDIFF:
            begin
                unit_b = last_in_reg;
            end
            S_TCMP:
            begin
                unit_a = {16'd0, timeout_reg};
                unit_b = diff_reg;
            end
            default:
            begin
                unit_b = '1;
            end
        endcase
    end

    assign unit_res    = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_borrow = unit_res[32];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_STATUS;
                if (func_reg == FUNC_TICK && enable_reg)
                begin
                    state_next = S_FETCH;
                end
                else if (func_reg == FUNC_MESSAGE && enable_reg && !app_busy_reg &&
                         (msg_reg[7] || thru_busy_reg))
                begin
                    state_next = S_THRU_OUT;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_THRU_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_THRU_APP;
                end
            end
            S_THRU_APP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_DUE;
            end
            S_DUE:
            begin
                if (q_stat.empty || n_max || unit_borrow)
                begin
                    state_next = S_FINISH;
                end
                else if (head_blocked)
                begin
                    state_next = S_TDIFF;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_TDIFF:
            begin
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                state_next = unit_borrow ? S_POP : S_FINISH;
            end
            S_POP:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        out_load     = 1'b0;
        out_dest     = DEST_STATUS;
        out_msg      = '0;
        out_code     = CODE_OK;
        out_last     = 1'b1;
        tick_load    = 1'b0;
        last_in_load = 1'b0;
        code_load    = 1'b0;
        code_val     = CODE_OK;
        thru_clear   = 1'b0;
        thru_update  = 1'b0;
        app_update   = 1'b0;
        pend_load    = 1'b0;
        pend_clear   = 1'b0;
        diff_load    = 1'b0;
        n_clear      = 1'b0;
        q_push       = 1'b0;
        q_pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DISPATCH:
            begin
                code_load  = 1'b1;
                pend_clear = 1'b1;
                n_clear    = 1'b1;
                case (func_reg)
                    FUNC_TICK:
                    begin
                        tick_load = 1'b1;
                        code_val  = enable_reg ? CODE_OK : CODE_INACTIVE;
                    end
                    FUNC_MESSAGE:
                    begin
                        if (!enable_reg)
                        begin
                            code_val = CODE_INACTIVE;
                        end
                        else if (app_busy_reg)
                        begin
                            code_val = CODE_REFUSED;
                        end
                        else
                        begin
                            last_in_load = 1'b1;
                            code_val     = (!msg_reg[7] && !thru_busy_reg) ?
                                           CODE_STRAY : CODE_OK;
                        end
                    end
                    FUNC_ENQUEUE:
                    begin
                        if (q_stat.full)
                        begin
                            code_val = CODE_FULL;
                        end
                        else
                        begin
                            q_push = 1'b1;
                        end
                    end
                    default:
                    begin
                        code_val = CODE_OK;
                    end
                endcase
            end
            S_STATUS:
            begin
                out_load = out_free;
                out_code = code_reg;
            end
            S_THRU_OUT:
            begin
                out_load = out_free;
                out_dest = DEST_MIDI;
                out_msg  = msg_reg;
                out_last = 1'b0;
            end
            S_THRU_APP:
            begin
                out_load    = out_free;
                out_dest    = DEST_APP;
                out_msg     = msg_reg;
                thru_update = out_free;
            end
            S_FETCH:
            begin
            end
            S_DUE:
            begin
            end
            S_TDIFF:
            begin
                diff_load = 1'b1;
            end
            S_TCMP:
            begin
                thru_clear = unit_borrow;
            end
            S_POP:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    out_load   = pend_valid_reg;
                    out_dest   = DEST_MIDI;
                    out_msg    = pend_msg_reg;
                    out_last   = 1'b0;
                    pend_load  = 1'b1;
                    q_pop      = 1'b1;
                    app_update = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    pend_clear = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_dest = DEST_MIDI;
                        out_msg  = pend_msg_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enable_reg     <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
            tick_reg       <= '0;
            last_in_reg    <= '0;
            thru_busy_reg  <= 1'b0;
            app_busy_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                    end
                    REG_TIMEOUT:
                    begin
                        timeout_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (tick_load)
            begin
                tick_reg <= unit_res[31:0];
            end
            if (last_in_load)
            begin
                last_in_reg <= tick_reg;
            end
            if (thru_clear)
            begin
                thru_busy_reg <= 1'b0;
            end
            else if (thru_update)
            begin
                thru_busy_reg <= track_sysex(thru_busy_reg, msg_reg);
            end
            if (app_update)
            begin
                app_busy_reg <= track_sysex(app_busy_reg, q_msg);
            end
            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (n_clear)
            begin
                n_reg <= '0;
            end
            else if (q_pop)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= s_axis_tuser;
            msg_reg  <= s_axis_tdata[31:0];
            due_reg  <= s_axis_tdata[63:32];
        end
        if (code_load)
        begin
            code_reg <= code_val;
        end
        if (pend_load)
        begin
            pend_msg_reg <= q_msg;
        end
        if (diff_load)
        begin
            diff_reg <= unit_res[31:0];
        end
        if (out_load)
        begin
            out_dest_reg  <= out_dest;
            out_msg_reg   <= out_msg;
            out_stamp_reg <= tick_reg;
            out_code_reg  <= out_code;
            out_last_reg  <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_stamp_reg, out_msg_reg};
    assign m_axis_tuser  = {out_code_reg, out_dest_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
